// ===== hdl/pnmdec_pkg.sv =====
// ----------------------------------------------------------------------------
// pnmdec_pkg
// Types, character codes and result codes shared by the anymap decoder.
// ----------------------------------------------------------------------------
package pnmdec_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_file;
    } in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  sample;
        logic [1:0]  plane;
        logic        row_end;
        logic        image_end;
        logic        last_in_run;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [1:0]  planes;
        logic [15:0] source_maxval;
        logic [2:0]  error_code;
    } out_t;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ERR_UNSUPPORTED = 3'd2;
    localparam logic [2:0] ERR_BAD_WIDTH   = 3'd3;
    localparam logic [2:0] ERR_BAD_HEIGHT  = 3'd4;
    localparam logic [2:0] ERR_BAD_MAXVAL  = 3'd5;
    localparam logic [2:0] ERR_EARLY_END   = 3'd6;

    localparam logic [2:0] FMT_PBM_ASCII = 3'd1;
    localparam logic [2:0] FMT_PPM_ASCII = 3'd3;
    localparam logic [2:0] FMT_PBM_RAW   = 3'd4;
    localparam logic [2:0] FMT_PPM_RAW   = 3'd6;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_1     = 8'h31;
    localparam logic [7:0] CHAR_6     = 8'h36;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_P     = 8'h50;

    localparam int         TOKEN_BITS = 25;
    localparam logic [24:0] TOKEN_SAT = 25'h1ff_ffff;

    typedef enum logic [2:0] {
        PH_MAGIC, PH_WIDTH, PH_HEIGHT, PH_MAXVAL, PH_ASCII, PH_RAW, PH_RAWBIT, PH_IDLE
    } phase_t;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_RESULT, ACT_ABORT, ACT_DIRECT, ACT_DIV, ACT_BITS
    } act_t;

    typedef enum logic [1:0] {
        ST_IN, ST_DECODE, ST_DIV
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic commit;
        logic push;
        logic bit_step;
        logic div_start;
    } dp_cmd_t;

    typedef struct packed {
        act_t act;
        logic out_free;
        logic div_done;
        logic bits_last;
    } dp_stat_t;

endpackage

// ===== hdl/pnmdec_div.sv =====
// ----------------------------------------------------------------------------
// pnmdec_div
// Sample normalizer: floor(255*v/maxval) for v <= maxval, one quotient bit
// per cycle for an 8-bit quotient.
// ----------------------------------------------------------------------------
module pnmdec_div #(
    parameter int W = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [7:0]   quot,
    output logic         done
);

    logic [W+7:0] prod;
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         ge;

    logic [W-1:0] rem_reg, rem_next;
    logic [7:0]   low_reg, low_next;
    logic [7:0]   quot_reg, quot_next;
    logic [W-1:0] div_reg, div_next;
    logic [2:0]   step_reg, step_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;

    assign prod  = {dividend, 8'h00} - {8'h00, dividend};
    assign trial = {rem_reg, low_reg[7]};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            rem_next  = prod[W+7:8];
            low_next  = prod[7:0];
            div_next  = divisor;
            step_next = 3'd0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so W bits hold it
            rem_next  = ge ? diff[W-1:0] : trial[W-1:0];
            low_next  = {low_reg[6:0], 1'b0};
            quot_next = {quot_reg[6:0], ge};
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        div_reg  <= div_next;
    end

    assign quot = quot_reg;
    assign done = done_reg;

endmodule

// ===== hdl/pnmdec_dp.sv =====
// ----------------------------------------------------------------------------
// pnmdec_dp
// Decoder datapath: parse state, token builder, image counters, normalizer
// and the result register.
// ----------------------------------------------------------------------------
module pnmdec_dp #(
    parameter int DIM_BITS    = 16,
    parameter int MAXVAL_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pnmdec_pkg::in_t     byte_data,
    input  pnmdec_pkg::dp_cmd_t cmd,
    output pnmdec_pkg::dp_stat_t stat,
    input  logic                result_ready,
    output logic                result_valid,
    output pnmdec_pkg::out_t    result_data
);

    localparam int TB = pnmdec_pkg::TOKEN_BITS;
    localparam int MV = MAXVAL_BITS;

    logic [7:0]              c_reg, c_next;
    logic                    eof_reg, eof_next;
    pnmdec_pkg::phase_t      phase_reg, phase_next;
    logic [2:0]              type_reg, type_next;
    logic                    comment_reg, comment_next;
    logic [TB-1:0]           tok_val_reg, tok_val_next;
    logic [2:0]              tok_len_reg, tok_len_next;
    logic                    tok_lead_reg, tok_lead_next;
    logic [DIM_BITS-1:0]     width_reg, width_next;
    logic [DIM_BITS-1:0]     height_reg, height_next;
    logic [MV-1:0]           maxval_reg, maxval_next;
    logic [DIM_BITS-1:0]     col_reg, col_next;
    logic [DIM_BITS-1:0]     row_reg, row_next;
    logic [1:0]              plane_reg, plane_next;
    logic [2:0]              bit_idx_reg, bit_idx_next;
    logic                    out_valid_reg, out_valid_next;
    pnmdec_pkg::out_t        out_reg, out_next;

    logic                    is_sp, is_hash, is_dig, is_term, tl_zero, hdr_phase;
    logic [TB-1:0]           tc_val;
    logic [2:0]              tc_len;
    logic                    tc_lead;
    logic [TB+3:0]           mul10;
    logic [2:0]              hdr_err;
    logic                    hdr_done, hdr_finish, is_bitmap;
    logic                    over_dim, over_mv, over_255, val_zero;
    logic                    ascii_emit;
    logic [TB-1:0]           ascii_val, v_norm;
    logic                    norm_over, norm_byp;
    logic [7:0]              direct_val;
    logic                    lp, lc, lr, at_end, left_le8, abort, adv;
    logic [1:0]              planes_cnt;
    logic [DIM_BITS-1:0]     left;
    pnmdec_pkg::act_t        act;
    logic [7:0]              div_q;
    logic                    div_done;

    // character classes, token, phase and format flags
    always_comb
    begin
        is_sp   = (c_reg == pnmdec_pkg::CHAR_SPACE) ||
                  (c_reg >= pnmdec_pkg::CHAR_TAB && c_reg <= pnmdec_pkg::CHAR_CR);
        is_hash = c_reg == pnmdec_pkg::CHAR_HASH;
        is_dig  = c_reg >= pnmdec_pkg::CHAR_0 && c_reg <= pnmdec_pkg::CHAR_9;
        is_term = is_sp || is_hash;
        tl_zero = tok_len_reg == 3'd0;
        hdr_phase = phase_reg == pnmdec_pkg::PH_MAGIC || phase_reg == pnmdec_pkg::PH_WIDTH ||
                    phase_reg == pnmdec_pkg::PH_HEIGHT || phase_reg == pnmdec_pkg::PH_MAXVAL;
        is_bitmap = type_reg == pnmdec_pkg::FMT_PBM_ASCII || type_reg == pnmdec_pkg::FMT_PBM_RAW;
        planes_cnt = (type_reg == pnmdec_pkg::FMT_PPM_ASCII ||
                      type_reg == pnmdec_pkg::FMT_PPM_RAW) ? 2'd3 : 2'd1;
    end

    // token builder: value the token holds once this byte joins it
    always_comb
    begin
        mul10   = (TB+4)'({tok_val_reg, 3'b000}) + (TB+4)'({tok_val_reg, 1'b0}) +
                  (TB+4)'(c_reg - pnmdec_pkg::CHAR_0);
        tc_len  = (tok_len_reg == 3'd7) ? 3'd7 : tok_len_reg + 3'd1;
        tc_val  = tok_val_reg;
        tc_lead = tok_lead_reg;
        if (phase_reg == pnmdec_pkg::PH_MAGIC)
        begin
            if (tl_zero)
                tc_val = TB'({c_reg, 8'h00});
            else if (tok_len_reg == 3'd1)
                tc_val = tok_val_reg | TB'(c_reg);
        end
        else if (tl_zero)
        begin
            tc_lead = is_dig;
            tc_val  = is_dig ? TB'(c_reg - pnmdec_pkg::CHAR_0) : '0;
        end
        else if (tok_lead_reg)
        begin
            if (is_dig)
                tc_val = (mul10 > (TB+4)'(pnmdec_pkg::TOKEN_SAT)) ? pnmdec_pkg::TOKEN_SAT
                                                                    : mul10[TB-1:0];
            else
                tc_lead = 1'b0;
        end
    end

    // header token checks
    always_comb
    begin
        val_zero = tok_val_reg == '0;
        over_dim = tok_val_reg[TB-1:DIM_BITS] != '0;
        over_mv  = tok_val_reg[TB-1:MV] != '0;
        over_255 = tok_val_reg[TB-1:8] != '0;
        hdr_finish = hdr_phase && !comment_reg && !tl_zero && is_term;
        hdr_err  = pnmdec_pkg::ERR_NONE;
        hdr_done = 1'b0;
        if (phase_reg == pnmdec_pkg::PH_MAGIC)
        begin
            if (tok_len_reg != 3'd2 || tok_val_reg[TB-1:8] != (TB-8)'(pnmdec_pkg::CHAR_P))
                hdr_err = pnmdec_pkg::ERR_BAD_MAGIC;
            else if (!(tok_val_reg[7:0] >= pnmdec_pkg::CHAR_1 &&
                       tok_val_reg[7:0] <= pnmdec_pkg::CHAR_6))
                hdr_err = pnmdec_pkg::ERR_UNSUPPORTED;
        end
        else if (phase_reg == pnmdec_pkg::PH_WIDTH)
        begin
            if (val_zero || over_dim)
                hdr_err = pnmdec_pkg::ERR_BAD_WIDTH;
        end
        else if (phase_reg == pnmdec_pkg::PH_HEIGHT)
        begin
            if (val_zero || over_dim)
                hdr_err = pnmdec_pkg::ERR_BAD_HEIGHT;
            else
                hdr_done = is_bitmap;
        end
        else if (phase_reg == pnmdec_pkg::PH_MAXVAL)
        begin
            if (val_zero || over_mv || (type_reg >= pnmdec_pkg::FMT_PBM_RAW && over_255))
                hdr_err = pnmdec_pkg::ERR_BAD_MAXVAL;
            else
                hdr_done = 1'b1;
        end
    end

    // body sample selection, image position and the action for this byte
    always_comb
    begin
        if (comment_reg)
            ascii_emit = 1'b0;
        else if (type_reg == pnmdec_pkg::FMT_PBM_ASCII)
            ascii_emit = !is_term;
        else if (!tl_zero)
            ascii_emit = is_term || eof_reg;
        else
            ascii_emit = !is_term && eof_reg;
        ascii_val  = is_term ? tok_val_reg : tc_val;
        v_norm     = (phase_reg == pnmdec_pkg::PH_RAW) ? TB'(c_reg) : ascii_val;
        norm_over  = v_norm > TB'(maxval_reg);
        norm_byp   = norm_over || maxval_reg == MV'(255);
        if (type_reg == pnmdec_pkg::FMT_PBM_ASCII)
            direct_val = (c_reg == pnmdec_pkg::CHAR_0) ? 8'hff : 8'h00;
        else
            direct_val = norm_over ? 8'hff : v_norm[7:0];

        lp       = (planes_cnt == 2'd1) || (plane_reg == 2'd2);
        lc       = ({1'b0, col_reg} + 1'b1) >= {1'b0, width_reg};
        lr       = ({1'b0, row_reg} + 1'b1) >= {1'b0, height_reg};
        at_end   = lp && lc && lr;
        left     = width_reg - col_reg;
        left_le8 = left <= DIM_BITS'(8);

        unique case (phase_reg)
            pnmdec_pkg::PH_MAGIC, pnmdec_pkg::PH_WIDTH,
            pnmdec_pkg::PH_HEIGHT, pnmdec_pkg::PH_MAXVAL:
                abort = !(hdr_finish && hdr_err != pnmdec_pkg::ERR_NONE);
            pnmdec_pkg::PH_ASCII:  abort = !(ascii_emit && at_end);
            pnmdec_pkg::PH_RAW:    abort = !at_end;
            pnmdec_pkg::PH_RAWBIT: abort = !(lr && left_le8);
            pnmdec_pkg::PH_IDLE:   abort = 1'b0;
        endcase

        if (eof_reg && abort)
            act = pnmdec_pkg::ACT_ABORT;
        else
        begin
            unique case (phase_reg)
                pnmdec_pkg::PH_MAGIC, pnmdec_pkg::PH_WIDTH,
                pnmdec_pkg::PH_HEIGHT, pnmdec_pkg::PH_MAXVAL:
                    act = (hdr_finish && (hdr_err != pnmdec_pkg::ERR_NONE || hdr_done))
                          ? pnmdec_pkg::ACT_RESULT : pnmdec_pkg::ACT_NONE;
                pnmdec_pkg::PH_ASCII:
                    if (!ascii_emit)
                        act = pnmdec_pkg::ACT_NONE;
                    else if (type_reg == pnmdec_pkg::FMT_PBM_ASCII || norm_byp)
                        act = pnmdec_pkg::ACT_DIRECT;
                    else
                        act = pnmdec_pkg::ACT_DIV;
                pnmdec_pkg::PH_RAW:
                    act = norm_byp ? pnmdec_pkg::ACT_DIRECT : pnmdec_pkg::ACT_DIV;
                pnmdec_pkg::PH_RAWBIT: act = pnmdec_pkg::ACT_BITS;
                pnmdec_pkg::PH_IDLE:   act = pnmdec_pkg::ACT_NONE;
            endcase
        end
    end

    pnmdec_div #(
        .W (MV)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (v_norm[MV-1:0]),
        .divisor  (maxval_reg),
        .quot     (div_q),
        .done     (div_done)
    );

    assign stat.act       = act;
    assign stat.out_free  = !out_valid_reg || result_ready;
    assign stat.div_done  = div_done;
    assign stat.bits_last = lc || bit_idx_reg == 3'd7;

    assign adv = cmd.bit_step ||
                 (cmd.commit && !eof_reg &&
                  (phase_reg == pnmdec_pkg::PH_RAW ||
                   (phase_reg == pnmdec_pkg::PH_ASCII && ascii_emit)));

    // state update
    always_comb
    begin
        c_next        = c_reg;
        eof_next      = eof_reg;
        phase_next    = phase_reg;
        type_next     = type_reg;
        comment_next  = comment_reg;
        tok_val_next  = tok_val_reg;
        tok_len_next  = tok_len_reg;
        tok_lead_next = tok_lead_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        maxval_next   = maxval_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        plane_next    = plane_reg;
        bit_idx_next  = bit_idx_reg;

        if (cmd.load)
        begin
            c_next       = byte_data.byte_value;
            eof_next     = byte_data.end_of_file;
            bit_idx_next = 3'd0;
        end

        if (cmd.bit_step)
            bit_idx_next = bit_idx_reg + 3'd1;

        // advance raster position by one sample
        if (adv)
        begin
            if (!lp)
                plane_next = plane_reg + 2'd1;
            else
            begin
                plane_next = 2'd0;
                if (!lc)
                    col_next = col_reg + 1'b1;
                else
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                    if (lr)
                        phase_next = pnmdec_pkg::PH_IDLE;
                end
            end
        end

        if (cmd.commit && !eof_reg)
        begin
            if (hdr_phase)
            begin
                if (comment_reg)
                begin
                    if (c_reg == pnmdec_pkg::CHAR_LF)
                        comment_next = 1'b0;
                end
                else if (tl_zero)
                begin
                    if (is_hash)
                        comment_next = 1'b1;
                    else if (!is_sp)
                    begin
                        tok_val_next  = tc_val;
                        tok_len_next  = tc_len;
                        tok_lead_next = tc_lead;
                    end
                end
                else if (is_term)
                begin
                    tok_val_next  = '0;
                    tok_len_next  = 3'd0;
                    tok_lead_next = 1'b0;
                    if (hdr_err != pnmdec_pkg::ERR_NONE)
                        phase_next = pnmdec_pkg::PH_IDLE;
                    else
                    begin
                        if (phase_reg == pnmdec_pkg::PH_MAGIC)
                        begin
                            type_next  = 3'(tok_val_reg[7:0] - pnmdec_pkg::CHAR_0);
                            phase_next = pnmdec_pkg::PH_WIDTH;
                        end
                        else if (phase_reg == pnmdec_pkg::PH_WIDTH)
                        begin
                            width_next = tok_val_reg[DIM_BITS-1:0];
                            phase_next = pnmdec_pkg::PH_HEIGHT;
                        end
                        else if (phase_reg == pnmdec_pkg::PH_HEIGHT)
                        begin
                            height_next = tok_val_reg[DIM_BITS-1:0];
                            if (is_bitmap)
                                maxval_next = MV'(1);
                            else
                                phase_next = pnmdec_pkg::PH_MAXVAL;
                        end
                        else
                            maxval_next = tok_val_reg[MV-1:0];

                        if (hdr_done)
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            plane_next = 2'd0;
                            if (type_reg <= pnmdec_pkg::FMT_PPM_ASCII)
                            begin
                                phase_next   = pnmdec_pkg::PH_ASCII;
                                comment_next = is_hash;
                            end
                            else if (type_reg == pnmdec_pkg::FMT_PBM_RAW)
                                phase_next = pnmdec_pkg::PH_RAWBIT;
                            else
                                phase_next = pnmdec_pkg::PH_RAW;
                        end
                        else if (is_hash)
                            comment_next = 1'b1;
                    end
                end
                else
                begin
                    tok_val_next  = tc_val;
                    tok_len_next  = tc_len;
                    tok_lead_next = tc_lead;
                end
            end
            else if (phase_reg == pnmdec_pkg::PH_ASCII)
            begin
                if (comment_reg)
                begin
                    if (c_reg == pnmdec_pkg::CHAR_LF)
                        comment_next = 1'b0;
                end
                else if (type_reg == pnmdec_pkg::FMT_PBM_ASCII || tl_zero || is_term)
                begin
                    if (is_hash)
                        comment_next = 1'b1;
                    if (!tl_zero)
                    begin
                        tok_val_next  = '0;
                        tok_len_next  = 3'd0;
                        tok_lead_next = 1'b0;
                    end
                    else if (!is_term && type_reg != pnmdec_pkg::FMT_PBM_ASCII)
                    begin
                        tok_val_next  = tc_val;
                        tok_len_next  = tc_len;
                        tok_lead_next = tc_lead;
                    end
                end
                else
                begin
                    tok_val_next  = tc_val;
                    tok_len_next  = tc_len;
                    tok_lead_next = tc_lead;
                end
            end
        end

        // final byte of a file: back to the start of a new file
        if (cmd.commit && eof_reg)
        begin
            phase_next    = pnmdec_pkg::PH_MAGIC;
            type_next     = 3'd0;
            comment_next  = 1'b0;
            tok_val_next  = '0;
            tok_len_next  = 3'd0;
            tok_lead_next = 1'b0;
            width_next    = '0;
            height_next   = '0;
            maxval_next   = '0;
            col_next      = '0;
            row_next      = '0;
            plane_next    = 2'd0;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        if (cmd.push)
        begin
            out_valid_next       = 1'b1;
            out_next             = '0;
            out_next.last_in_run = 1'b1;
            unique case (act)
                pnmdec_pkg::ACT_RESULT:
                    if (hdr_err != pnmdec_pkg::ERR_NONE)
                    begin
                        out_next.result_kind = pnmdec_pkg::KIND_ERROR;
                        out_next.error_code  = hdr_err;
                    end
                    else
                    begin
                        out_next.result_kind  = pnmdec_pkg::KIND_HEADER;
                        out_next.image_width  = 16'(width_reg);
                        out_next.planes       = planes_cnt;
                        if (phase_reg == pnmdec_pkg::PH_HEIGHT)
                        begin
                            out_next.image_height  = 16'(tok_val_reg[DIM_BITS-1:0]);
                            out_next.source_maxval = 16'd1;
                        end
                        else
                        begin
                            out_next.image_height  = 16'(height_reg);
                            out_next.source_maxval = 16'(tok_val_reg[MV-1:0]);
                        end
                    end
                pnmdec_pkg::ACT_ABORT:
                begin
                    out_next.result_kind = pnmdec_pkg::KIND_ERROR;
                    out_next.error_code  = pnmdec_pkg::ERR_EARLY_END;
                end
                pnmdec_pkg::ACT_DIRECT, pnmdec_pkg::ACT_DIV, pnmdec_pkg::ACT_BITS,
                pnmdec_pkg::ACT_NONE:
                begin
                    out_next.result_kind = pnmdec_pkg::KIND_SAMPLE;
                    out_next.plane       = plane_reg;
                    out_next.row_end     = lp && lc;
                    out_next.image_end   = at_end;
                    if (act == pnmdec_pkg::ACT_DIV)
                        out_next.sample = div_q;
                    else if (act == pnmdec_pkg::ACT_BITS)
                    begin
                        // set bit is black
                        out_next.sample      = c_reg[~bit_idx_reg] ? 8'h00 : 8'hff;
                        out_next.last_in_run = stat.bits_last;
                    end
                    else
                        out_next.sample = direct_val;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pnmdec_pkg::PH_MAGIC;
            type_reg      <= 3'd0;
            comment_reg   <= 1'b0;
            tok_val_reg   <= '0;
            tok_len_reg   <= 3'd0;
            tok_lead_reg  <= 1'b0;
            width_reg     <= '0;
            height_reg    <= '0;
            maxval_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            plane_reg     <= 2'd0;
            bit_idx_reg   <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            type_reg      <= type_next;
            comment_reg   <= comment_next;
            tok_val_reg   <= tok_val_next;
            tok_len_reg   <= tok_len_next;
            tok_lead_reg  <= tok_lead_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            maxval_reg    <= maxval_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            plane_reg     <= plane_next;
            bit_idx_reg   <= bit_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg   <= c_next;
        eof_reg <= eof_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

// ===== hdl/pnmdec_ctrl.sv =====
// ----------------------------------------------------------------------------
// pnmdec_ctrl
// Sequencer: takes one byte, then issues the datapath commands that
// deliver its results and update the parse state.
// ----------------------------------------------------------------------------
module pnmdec_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  pnmdec_pkg::dp_stat_t stat,
    output pnmdec_pkg::dp_cmd_t  cmd
);

    pnmdec_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pnmdec_pkg::ST_IN;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pnmdec_pkg::ST_IN:
                if (byte_valid)
                    state_next = pnmdec_pkg::ST_DECODE;
            pnmdec_pkg::ST_DECODE:
                unique case (stat.act)
                    pnmdec_pkg::ACT_NONE:
                        state_next = pnmdec_pkg::ST_IN;
                    pnmdec_pkg::ACT_RESULT, pnmdec_pkg::ACT_ABORT, pnmdec_pkg::ACT_DIRECT:
                        if (stat.out_free)
                            state_next = pnmdec_pkg::ST_IN;
                    pnmdec_pkg::ACT_DIV:
                        state_next = pnmdec_pkg::ST_DIV;
                    pnmdec_pkg::ACT_BITS:
                        if (stat.out_free && stat.bits_last)
                            state_next = pnmdec_pkg::ST_IN;
                endcase
            pnmdec_pkg::ST_DIV:
                if (stat.div_done && stat.out_free)
                    state_next = pnmdec_pkg::ST_IN;
            default:
                state_next = pnmdec_pkg::ST_IN;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        byte_ready = 1'b0;
        unique case (state_reg)
            pnmdec_pkg::ST_IN:
            begin
                byte_ready = 1'b1;
                cmd.load   = byte_valid;
            end
            pnmdec_pkg::ST_DECODE:
                unique case (stat.act)
                    pnmdec_pkg::ACT_NONE:
                        cmd.commit = 1'b1;
                    pnmdec_pkg::ACT_RESULT, pnmdec_pkg::ACT_ABORT, pnmdec_pkg::ACT_DIRECT:
                    begin
                        cmd.push   = stat.out_free;
                        cmd.commit = stat.out_free;
                    end
                    pnmdec_pkg::ACT_DIV:
                        cmd.div_start = 1'b1;
                    pnmdec_pkg::ACT_BITS:
                    begin
                        // one unpacked bit per transfer slot
                        cmd.push     = stat.out_free;
                        cmd.bit_step = stat.out_free;
                        cmd.commit   = stat.out_free && stat.bits_last;
                    end
                endcase
            pnmdec_pkg::ST_DIV:
            begin
                cmd.push   = stat.div_done && stat.out_free;
                cmd.commit = stat.div_done && stat.out_free;
            end
            default:
                cmd = '0;
        endcase
    end

endmodule

// ===== hdl/pnm_image_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// pnm_image_stream_decoder
// Byte-stream decoder for portable anymap images, P1 through P6.
// ----------------------------------------------------------------------------
// One file byte is taken per transfer on the byte channel; each byte yields
// zero or more results (header, error or 8-bit sample) on the result channel,
// the last one flagged with last_in_run. A byte that only updates the header
// parser or gives a sample that needs no scaling goes straight out; a sample
// scaled by 255/maxval first passes through the eight-step normalizer, and a
// raw bitmap byte gives up to eight unpacked pixels, one per result transfer.
// A result register sits on the output, so a pending result does not
// hold back the next byte unless that byte also has a result to give.
module pnm_image_stream_decoder #(
    parameter int DIM_BITS    = 16,
    parameter int MAXVAL_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_ready,
    input  pnmdec_pkg::in_t  byte_data,
    output logic             result_valid,
    input  logic             result_ready,
    output pnmdec_pkg::out_t result_data
);

    pnmdec_pkg::dp_cmd_t  cmd;
    pnmdec_pkg::dp_stat_t stat;

    pnmdec_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    pnmdec_dp #(
        .DIM_BITS    (DIM_BITS),
        .MAXVAL_BITS (MAXVAL_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_data    (byte_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result_data  (result_data)
    );

endmodule

// ===== hdl/pnmdec_chk.sv =====
// ----------------------------------------------------------------------------
// pnmdec_chk
// Port-level checks for the anymap decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pnmdec_chk (
    input logic             clk,
    input logic             rst_n,
    input logic             byte_valid,
    input logic             byte_ready,
    input pnmdec_pkg::in_t  byte_data,
    input logic             result_valid,
    input logic             result_ready,
    input pnmdec_pkg::out_t result_data
);

    // hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // a byte is decoded before the next one is taken
    a_byte_gap: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready |=> !byte_ready)
        else $error("byte taken back to back");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.result_kind == pnmdec_pkg::KIND_ERROR ||
                         result_data.result_kind == pnmdec_pkg::KIND_HEADER)
        |-> result_data.last_in_run)
        else $error("header or error result not last of its byte");

    a_image_end_row: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.result_kind == pnmdec_pkg::KIND_SAMPLE &&
        result_data.image_end |-> result_data.row_end)
        else $error("image end without row end");

endmodule

bind pnm_image_stream_decoder pnmdec_chk u_pnmdec_chk (.*);
